>>> src/pfb_pkg.sv
// shared types and constants for the packet frame builder
// no dependencies; imported by every module of the block
package pfb_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadType = 2'd1;
  localparam logic [1:0] StBadLen  = 2'd2;
  localparam logic [1:0] StNoPkt   = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VERSION      = 3'd0,
    CFG_SOURCE_PORT  = 3'd1,
    CFG_CTRL_TYPE    = 3'd2,
    CFG_CTRL_DEST    = 3'd3,
    CFG_MSG_TYPE     = 3'd4,
    CFG_MSG_DEST     = 3'd5,
    CFG_MAX_LEN      = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_DATA = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic        func;
    logic [3:0]  packet_type;
    logic [11:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
    logic       end_of_packet;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] source_port;
    logic [3:0]  control_type_code;
    logic [15:0] control_dest_port;
    logic [3:0]  message_type_code;
    logic [15:0] message_dest_port;
    logic [11:0] max_payload_length;
  } cfg_t;

  // one classified item handed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  status;
    logic [15:0] dest;
    logic [15:0] len_type;
    logic        pad;
    logic        zero_len;
    logic [7:0]  data;
    logic        final_byte;
  } cmd_t;

endpackage

>>> src/pfb_cfg.sv
// configuration register file of the packet frame builder
// uses pfb_pkg for the register layout and index codes
module pfb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [pfb_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [pfb_pkg::CfgDataW-1:0]  wr_data_i,
  output pfb_pkg::cfg_t                 cfg_o
);
  import pfb_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_index_i))
        CFG_VERSION:     cfg_d.version            = wr_data_i[7:0];
        CFG_SOURCE_PORT: cfg_d.source_port        = wr_data_i;
        CFG_CTRL_TYPE:   cfg_d.control_type_code  = wr_data_i[3:0];
        CFG_CTRL_DEST:   cfg_d.control_dest_port  = wr_data_i;
        CFG_MSG_TYPE:    cfg_d.message_type_code  = wr_data_i[3:0];
        CFG_MSG_DEST:    cfg_d.message_dest_port  = wr_data_i;
        CFG_MAX_LEN:     cfg_d.max_payload_length = wr_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.version            <= 8'd1;
      cfg_q.source_port        <= 16'd0;
      cfg_q.control_type_code  <= 4'd0;
      cfg_q.control_dest_port  <= 16'd0;
      cfg_q.message_type_code  <= 4'd1;
      cfg_q.message_dest_port  <= 16'd0;
      cfg_q.max_payload_length <= 12'hFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/pfb_front.sv
// front end: checks start items, tracks the open packet, classifies each word
// uses pfb_pkg for item, config and command types
module pfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfb_pkg::cfg_t      cfg_i,
  input  pfb_pkg::in_item_t  item_i,
  input  logic               accept_i,
  output pfb_pkg::cmd_t      cmd_o
);
  import pfb_pkg::*;

  logic        open_q, open_d;
  logic [11:0] remaining_q, remaining_d;
  cmd_t        cmd;

  always_comb begin
    cmd            = '0;
    cmd.kind       = CMD_ERR;
    cmd.status     = StOk;
    cmd.len_type   = {item_i.packet_type, item_i.payload_length};
    cmd.pad        = ~item_i.payload_length[0];
    cmd.zero_len   = (item_i.payload_length == 12'd0);
    cmd.data       = item_i.payload_byte;
    cmd.final_byte = (remaining_q == 12'd1);
    open_d         = open_q;
    remaining_d    = remaining_q;

    if (!item_i.func) begin
      if (item_i.packet_type == cfg_i.control_type_code) begin
        cmd.dest = cfg_i.control_dest_port;
      end else begin
        cmd.dest = cfg_i.message_dest_port;
      end
      if (item_i.packet_type != cfg_i.control_type_code &&
          item_i.packet_type != cfg_i.message_type_code) begin
        cmd.status = StBadType;
      end else if (item_i.payload_length > cfg_i.max_payload_length) begin
        cmd.status = StBadLen;
      end else begin
        // a start while open simply drops the unfinished packet
        cmd.kind    = CMD_HDR;
        open_d      = !cmd.zero_len;
        remaining_d = item_i.payload_length;
      end
    end else if (!open_q) begin
      cmd.status = StNoPkt;
    end else begin
      cmd.kind    = CMD_DATA;
      remaining_d = remaining_q - 12'd1;
      if (cmd.final_byte) begin
        open_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      remaining_q <= 12'd0;
    end else if (accept_i) begin
      open_q      <= open_d;
      remaining_q <= remaining_d;
    end
  end

  assign cmd_o = cmd;

endmodule

>>> src/pfb_cmd_fifo.sv
// short command queue between front and back
// uses pfb_pkg for the command type and depth
module pfb_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pfb_pkg::cmd_t  push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output pfb_pkg::cmd_t  head_o,
  output logic           empty_o
);
  import pfb_pkg::*;

  cmd_t                 mem_q [CmdDepth];
  logic [CmdPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0]   count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CmdCntW'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

>>> src/pfb_back.sv
// back end: expands commands into bytes, keeps the checksum, holds the output word
// uses pfb_pkg for command, config and result types
module pfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfb_pkg::cfg_t       cfg_i,
  input  pfb_pkg::cmd_t       cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  output pfb_pkg::out_item_t  result_o,
  output logic                result_valid_o,
  input  logic                result_pop_i
);
  import pfb_pkg::*;

  localparam logic [3:0] StepHdrLast = 4'd6;
  localparam logic [3:0] StepPad     = 4'd7;
  localparam logic [3:0] StepHdrCkLo = 4'd8;
  localparam logic [3:0] StepHdrCkHi = 4'd9;
  localparam logic [3:0] StepDatCkLo = 4'd1;
  localparam logic [3:0] StepDatCkHi = 4'd2;

  logic [3:0]  step_q, step_d;
  logic [15:0] sum_q, sum_d;
  logic        odd_q, odd_d;
  out_item_t   out_q, out_d;
  logic        out_valid_q;

  logic        fire, done, acc, ck_lo, ck_hi;
  logic [15:0] base_sum, ck;
  logic        base_odd;
  logic [16:0] wide_sum;
  logic [15:0] word;

  assign fire = cmd_valid_i && (!out_valid_q || result_pop_i);
  assign ck   = ~sum_q;

  always_comb begin
    out_d         = '0;
    out_d.status  = StOk;
    acc           = 1'b0;
    ck_lo         = 1'b0;
    ck_hi         = 1'b0;
    done          = 1'b0;
    step_d        = step_q + 4'd1;
    case (cmd_i.kind)
      CMD_HDR: begin
        case (step_q)
          4'd0: out_d.out_byte = cfg_i.version;
          4'd1: out_d.out_byte = cfg_i.source_port[7:0];
          4'd2: out_d.out_byte = cfg_i.source_port[15:8];
          4'd3: out_d.out_byte = cmd_i.dest[7:0];
          4'd4: out_d.out_byte = cmd_i.dest[15:8];
          4'd5: out_d.out_byte = cmd_i.len_type[7:0];
          4'd6: out_d.out_byte = cmd_i.len_type[15:8];
          default: out_d.out_byte = 8'd0;
        endcase
        acc   = (step_q <= StepPad);
        ck_lo = (step_q == StepHdrCkLo);
        ck_hi = (step_q == StepHdrCkHi);
        if (step_q == StepHdrLast && !cmd_i.pad) begin
          step_d = StepHdrCkLo;
        end
        if (cmd_i.zero_len) begin
          done = ck_hi;
        end else if (cmd_i.pad) begin
          done = (step_q == StepPad);
        end else begin
          done = (step_q == StepHdrLast);
        end
      end
      CMD_DATA: begin
        out_d.out_byte = cmd_i.data;
        acc   = (step_q == 4'd0);
        ck_lo = (step_q == StepDatCkLo);
        ck_hi = (step_q == StepDatCkHi);
        done  = cmd_i.final_byte ? ck_hi : 1'b1;
      end
      default: begin
        out_d.status = cmd_i.status;
        done         = 1'b1;
      end
    endcase
    if (ck_lo) begin
      out_d.out_byte = ck[7:0];
    end
    if (ck_hi) begin
      out_d.out_byte      = ck[15:8];
      out_d.end_of_packet = 1'b1;
    end
    out_d.last = done;
  end

  // a header restarts the sum at its first byte; carry folds back in once
  always_comb begin
    if (cmd_i.kind == CMD_HDR && step_q == 4'd0) begin
      base_sum = 16'd0;
      base_odd = 1'b0;
    end else begin
      base_sum = sum_q;
      base_odd = odd_q;
    end
    word     = base_odd ? {out_d.out_byte, 8'd0} : {8'd0, out_d.out_byte};
    wide_sum = {1'b0, base_sum} + {1'b0, word};
    sum_d    = wide_sum[15:0] + {15'd0, wide_sum[16]};
    odd_d    = !base_odd;
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      sum_q       <= 16'd0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
        step_q      <= done ? 4'd0 : step_d;
        if (acc) begin
          sum_q <= sum_d;
          odd_q <= odd_d;
        end
      end else if (result_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cmd_pop_o      = fire && done;
  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

>>> src/packet_frame_builder_checksum_top.sv
// top level of the packet frame builder with ones' complement checksum
// uses pfb_pkg, pfb_cfg, pfb_front, pfb_cmd_fifo and pfb_back
//
//   channel   handshake                 payload
//   input     push / full               item_i (func, type, length, byte)
//   result    empty / pop               result_o (byte, status, last, eop)
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// an input word is taken every cycle while the four-entry command queue has room
// the back end sends one byte per cycle unless the result stalls: a start gives
// 7 to 10 bytes, a payload byte 1 or 3, an error 1, so the byte output sets the
// long-run item rate; the output register is reloaded in the cycle it is popped
// reset clears queue, packet state and checksum and loads config defaults

module packet_frame_builder_checksum_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  pfb_pkg::in_item_t             item_i,
  output logic                          empty,
  input  logic                          pop,
  output pfb_pkg::out_item_t            result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pfb_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pfb_pkg::*;

  cfg_t  cfg;
  cmd_t  front_cmd, head_cmd;
  logic  accept, head_empty, head_pop, result_valid;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign empty       = !result_valid;

  pfb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  pfb_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_i),
    .accept_i (accept),
    .cmd_o    (front_cmd)
  );

  pfb_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (front_cmd),
    .full_o      (full),
    .pop_i       (head_pop),
    .head_o      (head_cmd),
    .empty_o     (head_empty)
  );

  pfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (head_cmd),
    .cmd_valid_i    (!head_empty),
    .cmd_pop_o      (head_pop),
    .result_o       (result_o),
    .result_valid_o (result_valid),
    .result_pop_i   (pop)
  );

`ifndef SYNTHESIS
  a_eop_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.end_of_packet) |-> result_o.last)
    else $error("checksum high byte not marked last");

  a_err_byte_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != StOk) |-> (result_o.out_byte == 8'd0 && result_o.last))
    else $error("error result with data or without last");

  a_eop_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.end_of_packet) |-> (result_o.status == StOk))
    else $error("end of packet on an error result");

  a_pop_needs_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_pop |-> !head_empty)
    else $error("command popped from empty queue");
`endif

endmodule

>>> bench/pfb_tb_pkg.sv
// input function codes shared by the frame predictor and the bench top
// no dependencies; the block's own types come from pfb_pkg
package pfb_tb_pkg;

  typedef enum logic {
    FN_START = 1'b0,
    FN_BYTE  = 1'b1
  } func_e;

endpackage

>>> bench/pfb_frame_predictor.sv
// watches the input, result and config channels of the packet frame builder,
// predicts every framed byte with its checksum and compares it with the block
// depends on pfb_pkg and pfb_tb_pkg
module pfb_frame_predictor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  input  logic                          full,
  input  pfb_pkg::in_item_t             item_i,
  input  logic                          empty,
  input  logic                          pop,
  input  pfb_pkg::out_item_t            result_o,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [pfb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pfb_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;
  import pfb_tb_pkg::*;

  localparam cfg_t CfgDefault = '{
    version: 8'd1, source_port: 16'd0, control_type_code: 4'd0,
    control_dest_port: 16'd0, message_type_code: 4'd1,
    message_dest_port: 16'd0, max_payload_length: 12'hFFF
  };

  cfg_t        regs = CfgDefault;
  logic [11:0] bytes_left = '0;
  logic        pkt_open = 1'b0;
  logic [15:0] csum = '0;
  logic        hi_half = 1'b0;
  out_item_t   frame_q[$];
  int unsigned fails = 0;
  int unsigned words_seen = 0;

  assign fail_count_o = fails;

  task automatic report_mismatch(string what, logic [15:0] want_v, logic [15:0] got_v);
    fails++;
    $display("%0t: word %0d %s: expected %0h, got %0h", $time, words_seen, what,
             want_v, got_v);
  endtask

  // byte goes into the frame and into the folded ones' complement sum
  function automatic void add_byte(logic [7:0] b);
    logic [16:0] s;
    out_item_t   w;
    s = {1'b0, csum} + (hi_half ? {1'b0, b, 8'h00} : {9'd0, b});
    csum = s[15:0] + {15'd0, s[16]};
    hi_half = ~hi_half;
    w = '{out_byte: b, status: StOk, last: 1'b0, end_of_packet: 1'b0};
    frame_q.push_back(w);
  endfunction

  function automatic void add_checksum();
    logic [15:0] c;
    out_item_t   w;
    c = ~csum;
    w = '{out_byte: c[7:0], status: StOk, last: 1'b0, end_of_packet: 1'b0};
    frame_q.push_back(w);
    w = '{out_byte: c[15:8], status: StOk, last: 1'b0, end_of_packet: 1'b1};
    frame_q.push_back(w);
    pkt_open = 1'b0;
    bytes_left = '0;
  endfunction

  function automatic void predict_frame(in_item_t it);
    logic [15:0] dest;
    logic [15:0] len_type;
    logic        ok;
    out_item_t   w;
    w = '{out_byte: 8'h00, status: StOk, last: 1'b0, end_of_packet: 1'b0};
    ok = 1'b1;
    dest = regs.control_dest_port;
    if (it.func == FN_START) begin
      // control code wins when both codes match
      if (it.packet_type == regs.control_type_code) begin
        dest = regs.control_dest_port;
      end else if (it.packet_type == regs.message_type_code) begin
        dest = regs.message_dest_port;
      end else begin
        w.status = StBadType;
        ok = 1'b0;
      end
      if (ok && it.payload_length > regs.max_payload_length) begin
        w.status = StBadLen;
        ok = 1'b0;
      end
      if (!ok) begin
        frame_q.push_back(w);
      end else begin
        // a start drops any unfinished packet
        csum = '0;
        hi_half = 1'b0;
        len_type = {it.packet_type, it.payload_length};
        add_byte(regs.version);
        add_byte(regs.source_port[7:0]);
        add_byte(regs.source_port[15:8]);
        add_byte(dest[7:0]);
        add_byte(dest[15:8]);
        add_byte(len_type[7:0]);
        add_byte(len_type[15:8]);
        if (!it.payload_length[0]) add_byte(8'h00);
        if (it.payload_length == '0) begin
          add_checksum();
        end else begin
          pkt_open = 1'b1;
          bytes_left = it.payload_length;
        end
      end
    end else if (!pkt_open) begin
      w.status = StNoPkt;
      frame_q.push_back(w);
    end else begin
      add_byte(it.payload_byte);
      bytes_left = bytes_left - 12'd1;
      if (bytes_left == '0) add_checksum();
    end
    // flag the final word of this run
    w = frame_q.pop_back();
    w.last = 1'b1;
    frame_q.push_back(w);
  endfunction

  task automatic check_word(out_item_t got);
    out_item_t want;
    words_seen++;
    if (frame_q.size() == 0) begin
      report_mismatch("arrived with nothing expected", 16'd0, 16'(got));
    end else begin
      want = frame_q.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", 16'(want.out_byte), 16'(got.out_byte));
      if (got.status !== want.status)
        report_mismatch("status", 16'(want.status), 16'(got.status));
      if (got.last !== want.last)
        report_mismatch("last", 16'(want.last), 16'(got.last));
      if (got.end_of_packet !== want.end_of_packet)
        report_mismatch("end_of_packet", 16'(want.end_of_packet), 16'(got.end_of_packet));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      regs = CfgDefault;
      bytes_left = '0;
      pkt_open = 1'b0;
      csum = '0;
      hi_half = 1'b0;
      frame_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_VERSION:     regs.version = cfg_data_i[7:0];
          CFG_SOURCE_PORT: regs.source_port = cfg_data_i;
          CFG_CTRL_TYPE:   regs.control_type_code = cfg_data_i[3:0];
          CFG_CTRL_DEST:   regs.control_dest_port = cfg_data_i;
          CFG_MSG_TYPE:    regs.message_type_code = cfg_data_i[3:0];
          CFG_MSG_DEST:    regs.message_dest_port = cfg_data_i;
          CFG_MAX_LEN:     regs.max_payload_length = cfg_data_i[11:0];
          default: ;
        endcase
      end
      // a word popped now comes from an earlier input, so compare first
      if (pop && !empty) check_word(result_o);
      if (push && !full) predict_frame(item_i);
    end
    pending_o <= frame_q.size();
  end

endmodule

>>> bench/packet_frame_builder_checksum_top_tb.sv
// bench top for the packet frame builder: clock, reset, stimulus and verdict
// depends on pfb_pkg, pfb_tb_pkg, pfb_frame_predictor and the block's top level
module packet_frame_builder_checksum_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfb_pkg::*;
  import pfb_tb_pkg::*;

  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  in_item_t            item_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_item_t           result_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned items_sent = 0;
  int unsigned hold_asks = 0;
  int unsigned holds_served = 0;
  int unsigned quiet_cycles = 0;
  cfg_t        cur_cfg;

  packet_frame_builder_checksum_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pfb_frame_predictor u_frame_pred (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .item_i       (item_i),
    .empty        (empty),
    .pop          (pop),
    .result_o     (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // nothing accepted on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // result side, with a long hold-off on request to back up the block
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (hold_asks != holds_served) begin
        holds_served++;
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic send_start(logic [3:0] ptype, logic [11:0] len);
    in_item_t it;
    it.func = FN_START;
    it.packet_type = ptype;
    it.payload_length = len;
    it.payload_byte = $urandom_range(255);
    send(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.func = FN_BYTE;
    it.packet_type = $urandom_range(15);
    it.payload_length = $urandom_range(4095);
    it.payload_byte = b;
    send(it);
  endtask

  // wait until every expected word has been popped
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_config(cfg_t c);
    cfg_idx_e idx;
    cfg_valid_i <= 1'b1;
    for (int i = CFG_VERSION; i <= CFG_MAX_LEN; i++) begin
      idx = cfg_idx_e'(i);
      cfg_index_i <= idx;
      case (idx)
        CFG_VERSION:     cfg_data_i <= {8'd0, c.version};
        CFG_SOURCE_PORT: cfg_data_i <= c.source_port;
        CFG_CTRL_TYPE:   cfg_data_i <= {12'd0, c.control_type_code};
        CFG_CTRL_DEST:   cfg_data_i <= c.control_dest_port;
        CFG_MSG_TYPE:    cfg_data_i <= {12'd0, c.message_type_code};
        CFG_MSG_DEST:    cfg_data_i <= c.message_dest_port;
        default:         cfg_data_i <= {4'd0, c.max_payload_length};
      endcase
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.version = $urandom_range(255);
    c.source_port = $urandom_range(65535);
    c.control_type_code = $urandom_range(15);
    c.control_dest_port = $urandom_range(65535);
    c.message_type_code = $urandom_range(15);
    c.message_dest_port = $urandom_range(65535);
    case ($urandom_range(2))
      0:       c.max_payload_length = 12'hFFF;
      1:       c.max_payload_length = $urandom_range(15);
      default: c.max_payload_length = $urandom_range(4095);
    endcase
    return c;
  endfunction

  // mostly whole packets with random content, the rest cut-short packets,
  // bad starts and stray bytes
  task automatic run_traffic(int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned cap;
    int unsigned len;
    logic [3:0]  ptype;
    logic [3:0]  bad_type;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      ptype = $urandom_range(1) ? cur_cfg.control_type_code : cur_cfg.message_type_code;
      if (r < 70) begin
        cap = ($urandom_range(9) == 0) ? 60 : 12;
        if (cap > cur_cfg.max_payload_length) cap = cur_cfg.max_payload_length;
        len = $urandom_range(cap);
        send_start(ptype, len);
        repeat (len) send_byte($urandom_range(255));
      end else if (r < 78) begin
        // left open unless the length is zero; a later start drops it
        len = $urandom_range(cur_cfg.max_payload_length);
        send_start(ptype, len);
        if (len > 1) repeat ($urandom_range(len > 8 ? 7 : len - 1)) send_byte($urandom_range(255));
      end else if (r < 86) begin
        do bad_type = $urandom_range(15);
        while (bad_type == cur_cfg.control_type_code || bad_type == cur_cfg.message_type_code);
        send_start(bad_type, $urandom_range(4095));
      end else if (r < 93 && cur_cfg.max_payload_length < 12'hFFF) begin
        send_start(ptype, $urandom_range(4095, cur_cfg.max_payload_length + 1));
      end else begin
        send_byte($urandom_range(255));
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle = 17;
    recv_idle = 67;

    set_config('{version: 8'hFF, source_port: 16'hFFFF, control_type_code: 4'hF,
                 control_dest_port: 16'hA55A, message_type_code: 4'h3,
                 message_dest_port: 16'h0001, max_payload_length: 12'hFFF});
    send_byte(8'hFF);                 // no packet open
    send_start(4'h5, 12'h000);        // unknown type
    send_start(4'hF, 12'h000);        // empty payload, whole frame from one word
    send_start(4'h3, 12'h001);        // odd length, no pad
    send_byte(8'h00);
    send_start(4'hF, 12'h002);        // even length, pad byte
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_start(4'h3, 12'hFFF);        // longest length, abandoned below
    send_byte(8'h5A);
    send_start(4'h3, 12'h003);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h00);
    drain();
    set_config('{version: 8'h00, source_port: 16'h0000, control_type_code: 4'h7,
                 control_dest_port: 16'h1234, message_type_code: 4'h7,
                 message_dest_port: 16'h4321, max_payload_length: 12'h000});
    send_start(4'h7, 12'h001);        // over the length limit
    send_start(4'h7, 12'h000);        // both codes match, control port wins
    send_start(4'h0, 12'h000);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 17;
          recv_idle = 67;
          c = rand_cfg();
        end
        1: begin
          send_idle = 67;
          recv_idle = 17;
          c = '{version: 8'h00, source_port: 16'h0000, control_type_code: 4'h0,
                control_dest_port: 16'h0000, message_type_code: 4'hF,
                message_dest_port: 16'h0000, max_payload_length: 12'hFFF};
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          c = '{version: 8'hFF, source_port: 16'hFFFF, control_type_code: 4'hF,
                control_dest_port: 16'hFFFF, message_type_code: 4'h0,
                message_dest_port: 16'hFFFF, max_payload_length: 12'd0};
          c.max_payload_length = $urandom_range(40, 4);
        end
      endcase
      set_config(c);
      run_traffic(18);
      if (ph == 0) hold_asks++;
      run_traffic(20);
      drain();
      set_config(rand_cfg());
      run_traffic(40);
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
